>>> rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types, codes and default geometry of the set-associative tag store
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_W            = 64;
    localparam int CNT_W             = 32;
    localparam int CFG_DATA_W        = 3;
    localparam int DEF_TOTAL_LINES   = 512;
    localparam int DEF_OFFSET_BITS   = 5;
    localparam int DEF_MAX_WAYS      = 16;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_WAYS_LOG2 = 1'b0,
        CFG_MODE      = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_LRU      = 2'd0,
        MODE_NO_WALLOC = 2'd1,
        MODE_PF_ALWAYS = 2'd2,
        MODE_PF_MISS  = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        OP_STORE = 1'b0,
        OP_LOAD  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEMAND,
        ST_PF_READ,
        ST_PREFETCH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              opcode;
    } acc_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] access_count;
    } res_t;

endpackage

>>> rtl/set_assoc_cache_lru_prefetch.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_prefetch
// tag store of a set-associative cache with lru replacement and next-line
// prefetch, valid bits, tags and ranks held in one row-wide synchronous memory
// ----------------------------------------------------------------------------
// access: the row read is registered and the result is loaded into the output
//   register once the slot is free; each lookup is a memory read and then a
//   compare/modify/write-back; a next-line lookup ends before the next access
// reset: a clearing pass writes every memory row once, TOTAL_LINES/MAX_WAYS
//   rows (32 by default); no access is taken until it ends
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_prefetch #(
    parameter int TOTAL_LINES = sacl_pkg::DEF_TOTAL_LINES,
    parameter int OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS,
    parameter int MAX_WAYS    = sacl_pkg::DEF_MAX_WAYS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                acc_valid,
    output logic                                acc_ready,
    input  sacl_pkg::acc_t                      acc,
    output logic                                res_valid,
    input  logic                                res_ready,
    output sacl_pkg::res_t                      res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import sacl_pkg::*;

    // geometry: one memory row holds the widest possible set
    localparam int LL      = $clog2(TOTAL_LINES + 1) - 1;
    localparam int MWL     = $clog2(MAX_WAYS + 1) - 1;
    localparam int E       = 1 << MWL;
    localparam int ROWS    = (1 << LL) >> MWL;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int OFF_W   = (MWL > 0) ? MWL : 1;
    localparam int BLK_W   = ADDR_W - OFFSET_BITS;
    localparam int TAG_W   = BLK_W - LL + MWL;
    localparam int RANK_W  = (MWL > 0) ? MWL : 1;
    localparam int WAYS_W  = RANK_W + 1;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } line_t;

    typedef line_t [E-1:0] row_t;

    // tag memory, one set per row slice
    row_t mem [ROWS];

    state_t state_reg, state_next;
    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CFG_DATA_W-1:0] ways_log2_reg;
    mode_t mode_reg;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic load_reg, load_next;
    logic res_valid_reg, res_valid_next;
    logic hit_reg, hit_next;
    logic [CNT_W-1:0] hits_reg, hits_next;
    logic [CNT_W-1:0] accs_reg, accs_next;

    logic rd_en;
    logic [ROW_AW-1:0] rd_addr;
    row_t rd_row_reg;
    logic wr_en;
    logic [ROW_AW-1:0] wr_addr;
    row_t wr_row;

    // lookup datapath
    logic [2:0] eff_w;
    logic [LL-1:0] line_base;
    logic [ROW_AW-1:0] look_row;
    logic [OFF_W-1:0] look_off;
    logic [TAG_W-1:0] look_tag;
    logic [WAYS_W-1:0] ways;
    logic [WAYS_W-1:0] ways_m1;
    logic [E-1:0] in_set;
    logic look_hit;
    logic look_alloc;
    logic found_inv;
    logic [OFF_W-1:0] hit_idx;
    logic [OFF_W-1:0] inv_idx;
    logic [OFF_W-1:0] vic_idx;
    logic [OFF_W-1:0] t_idx;
    logic [WAYS_W-1:0] old_rank;
    row_t new_row;
    logic slot_free;
    logic want_pf;

    // ways beyond the row width act as the row width
    assign eff_w = (ways_log2_reg > 3'(MWL)) ? 3'(MWL) : ways_log2_reg;

    function automatic logic [ROW_AW-1:0] row_of(input logic [BLK_W-1:0] b,
                                                 input logic [2:0] w);
        logic [LL-1:0] lb;
        lb = LL'(b[LL-1:0] << w);
        return ROW_AW'(lb >> MWL);
    endfunction

    // set and tag of the block under lookup
    always_comb
    begin
        line_base = LL'(blk_reg[LL-1:0] << eff_w);
        look_row  = row_of(blk_reg, eff_w);
        look_off  = OFF_W'(line_base & LL'(E - 1));
        look_tag  = TAG_W'(blk_reg >> (LL - int'(eff_w)));
        ways      = WAYS_W'(1) << eff_w;
        ways_m1   = ways - WAYS_W'(1);
        for (int j = 0; j < E; j++)
        begin
            in_set[j] = ((OFF_W'(j) ^ look_off) >> eff_w) == '0;
        end
    end

    // hit search, first invalid way and lru victim, all in parallel
    always_comb
    begin
        logic is_max;
        logic found_vic;
        look_hit  = 1'b0;
        found_inv = 1'b0;
        found_vic = 1'b0;
        hit_idx   = '0;
        inv_idx   = '0;
        vic_idx   = '0;
        for (int j = 0; j < E; j++)
        begin
            if (in_set[j] && rd_row_reg[j].valid && rd_row_reg[j].tag == look_tag
                && !look_hit)
            begin
                look_hit = 1'b1;
                hit_idx  = OFF_W'(j);
            end
            if (in_set[j] && !rd_row_reg[j].valid && !found_inv)
            begin
                found_inv = 1'b1;
                inv_idx   = OFF_W'(j);
            end
        end
        for (int j = 0; j < E; j++)
        begin
            is_max = in_set[j];
            for (int k = 0; k < E; k++)
            begin
                if (in_set[k] && rd_row_reg[k].rank > rd_row_reg[j].rank)
                begin
                    is_max = 1'b0;
                end
            end
            if (is_max && !found_vic)
            begin
                found_vic = 1'b1;
                vic_idx   = OFF_W'(j);
            end
        end
    end

    // recency update of the touched way and the row to write back
    always_comb
    begin
        logic [WAYS_W-1:0] r;
        look_alloc = (state_reg == ST_PREFETCH)
                  || !(mode_reg == MODE_NO_WALLOC && load_reg == OP_STORE);
        priority if (look_hit)
        begin
            t_idx    = hit_idx;
            old_rank = WAYS_W'(rd_row_reg[hit_idx].rank);
        end
        else if (found_inv)
        begin
            t_idx    = inv_idx;
            old_rank = ways;
        end
        else
        begin
            t_idx    = vic_idx;
            old_rank = WAYS_W'(rd_row_reg[vic_idx].rank);
        end
        new_row = rd_row_reg;
        for (int j = 0; j < E; j++)
        begin
            r = WAYS_W'(rd_row_reg[j].rank);
            if (in_set[j] && OFF_W'(j) != t_idx && rd_row_reg[j].valid && r < old_rank)
            begin
                if (r + WAYS_W'(1) < ways)
                begin
                    new_row[j].rank = RANK_W'(r + WAYS_W'(1));
                end
                else
                begin
                    new_row[j].rank = RANK_W'(ways_m1);
                end
            end
        end
        new_row[t_idx].rank  = '0;
        new_row[t_idx].valid = 1'b1;
        new_row[t_idx].tag   = look_tag;
    end

    // the output register may take a new result this cycle
    assign slot_free = !res_valid_reg || res_ready;
    assign want_pf   = (mode_reg == MODE_PF_ALWAYS)
                    || (mode_reg == MODE_PF_MISS && !look_hit);

    // sequencer: clearing pass, demand lookup, optional next-line lookup
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        blk_next       = blk_reg;
        load_next      = load_reg;
        res_valid_next = res_valid_reg && !res_ready;
        hit_next       = hit_reg;
        hits_next      = hits_reg;
        accs_next      = accs_reg;
        acc_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = look_row;
        wr_en          = 1'b0;
        wr_addr        = look_row;
        wr_row         = new_row;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_row       = '0;
                clr_cnt_next = clr_cnt_reg + ROW_AW'(1);
                if (clr_cnt_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                acc_ready = 1'b1;
                if (acc_valid)
                begin
                    blk_next   = acc.address[ADDR_W-1:OFFSET_BITS];
                    load_next  = acc.opcode;
                    rd_en      = 1'b1;
                    rd_addr    = row_of(acc.address[ADDR_W-1:OFFSET_BITS], eff_w);
                    state_next = ST_DEMAND;
                end
            end
            ST_DEMAND:
            begin
                // hold the read row until the result slot is free
                if (slot_free)
                begin
                    wr_en          = look_hit || look_alloc;
                    res_valid_next = 1'b1;
                    hit_next       = look_hit;
                    if (accs_reg != '1)
                    begin
                        accs_next = accs_reg + CNT_W'(1);
                    end
                    if (look_hit && hits_reg != '1)
                    begin
                        hits_next = hits_reg + CNT_W'(1);
                    end
                    if (want_pf)
                    begin
                        blk_next   = blk_reg + BLK_W'(1);
                        state_next = ST_PF_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PF_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_PREFETCH;
            end
            ST_PREFETCH:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // tag memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            hits_reg      <= '0;
            accs_reg      <= '0;
            ways_log2_reg <= CFG_DATA_W'(1);
            mode_reg      <= MODE_LRU;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
            hits_reg      <= hits_next;
            accs_reg      <= accs_next;
            // configuration transaction
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_WAYS_LOG2: ways_log2_reg <= cfg_data;
                    CFG_MODE:      mode_reg      <= mode_t'(cfg_data[1:0]);
                    default:       mode_reg      <= mode_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        load_reg <= load_next;
        hit_reg  <= hit_next;
    end

    assign cfg_ready        = 1'b1;
    assign res_valid        = res_valid_reg;
    assign res.hit          = hit_reg;
    assign res.hit_count    = hits_reg;
    assign res.access_count = accs_reg;

endmodule

>>> rtl/sacl_chk.sv
// ----------------------------------------------------------------------------
// sacl_chk
// port-level checks of the tag store, attached to the top level by bind
// ----------------------------------------------------------------------------
module sacl_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            acc_valid,
    input logic                            acc_ready,
    input sacl_pkg::acc_t                  acc,
    input logic                            res_valid,
    input logic                            res_ready,
    input sacl_pkg::res_t                  res,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic                            cfg_index,
    input logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sacl_pkg::*;

    // a waiting result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // one access in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid && acc_ready |=> !acc_ready)
        else $error("access taken while one is in flight");

    // hits never outnumber accesses
    a_hit_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.hit_count <= res.access_count)
        else $error("hit count above access count");

    // a hit always shows in the count
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.hit |-> res.hit_count != '0)
        else $error("hit with zero hit count");

endmodule

bind set_assoc_cache_lru_prefetch sacl_chk u_sacl_chk (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the set-associative tag store: a behavioural copy of
// the lru and prefetch rules predicts hit and counters for every access
// ----------------------------------------------------------------------------
class hit_tracker;
    localparam int LINES = 512;
    localparam int OFFS  = 5;

    bit                 vld [LINES];
    bit [63:0]          tags [LINES];
    bit [3:0]           rank [LINES];
    bit [31:0]          hits;
    bit [31:0]          accesses;
    bit [2:0]           ways_lg;
    sacl_pkg::mode_t    cur_mode;
    sacl_pkg::res_t     pending [$];
    int                 errors;

    function void clear();
        foreach (vld[i])
        begin
            vld[i] = 0;
            tags[i] = 0;
            rank[i] = 0;
        end
        hits = 0;
        accesses = 0;
        ways_lg = 1;
        cur_mode = sacl_pkg::MODE_LRU;
        errors = 0;
    endfunction

    function void promote(int base, int ways, int t, int old_rank);
        for (int i = 0; i < ways; i++)
        begin
            if (base + i != t && vld[base + i] && rank[base + i] < old_rank)
            begin
                if (rank[base + i] + 1 < ways)
                    rank[base + i]++;
                else
                    rank[base + i] = 4'(ways - 1);
            end
        end
        rank[t] = 0;
    endfunction

    function bit probe(bit [58:0] blk, bit alloc);
        int w;
        int ways;
        int sb;
        int base;
        int victim;
        bit [63:0] tg;
        w = (ways_lg > 4) ? 4 : int'(ways_lg);
        ways = 1 << w;
        sb = 9 - w;
        base = int'((blk & ((64'd1 << sb) - 1)) << w);
        tg = 64'(blk >> sb);
        for (int i = 0; i < ways; i++)
            if (vld[base + i] && tags[base + i] == tg)
            begin
                promote(base, ways, base + i, rank[base + i]);
                return 1'b1;
            end
        if (!alloc)
            return 1'b0;
        for (int i = 0; i < ways; i++)
            if (!vld[base + i])
            begin
                vld[base + i] = 1;
                tags[base + i] = tg;
                promote(base, ways, base + i, ways);
                return 1'b0;
            end
        victim = base;
        for (int i = 1; i < ways; i++)
            if (rank[base + i] > rank[victim])
                victim = base + i;
        tags[victim] = tg;
        promote(base, ways, victim, rank[victim]);
        return 1'b0;
    endfunction

    // note an accepted access and queue its expected result
    function void note_access(sacl_pkg::acc_t a);
        bit [58:0] blk;
        bit h;
        sacl_pkg::res_t r;
        blk = 59'(a.address >> OFFS);
        h = probe(blk, !(cur_mode == sacl_pkg::MODE_NO_WALLOC
                         && a.opcode == sacl_pkg::OP_STORE));
        if (accesses != 32'hFFFF_FFFF)
            accesses++;
        if (h && hits != 32'hFFFF_FFFF)
            hits++;
        if (cur_mode == sacl_pkg::MODE_PF_ALWAYS || (cur_mode == sacl_pkg::MODE_PF_MISS && !h))
            void'(probe(blk + 59'd1, 1'b1));
        r.hit = h;
        r.hit_count = hits;
        r.access_count = accesses;
        pending.push_back(r);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(sacl_pkg::res_t got);
        sacl_pkg::res_t want;
        if (pending.size() == 0)
        begin
            report("result with nothing outstanding");
            return;
        end
        want = pending.pop_front();
        if (got.hit !== want.hit)
            report($sformatf("hit %0b want %0b", got.hit, want.hit));
        if (got.hit_count !== want.hit_count)
            report($sformatf("hit_count %0d want %0d", got.hit_count, want.hit_count));
        if (got.access_count !== want.access_count)
            report($sformatf("access_count %0d want %0d",
                             got.access_count, want.access_count));
    endtask
endclass

module tb_top;
    import sacl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic           clk = 0;
    logic           rst_n = 0;
    logic           acc_valid = 0;
    logic           acc_ready;
    acc_t           acc = '0;
    logic           res_valid;
    logic           res_ready = 0;
    res_t           res;
    logic           cfg_valid = 0;
    logic           cfg_ready;
    logic           cfg_index = 0;
    logic [2:0]     cfg_data = '0;

    hit_tracker     tracker;
    int             cycles = 0;
    bit             calm = 0;       // no idling in the closing stretch
    bit [63:0]      hot_base;

    set_assoc_cache_lru_prefetch i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: sample at the edge, stall in random bursts
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                tracker.check_result(res);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                res_ready <= 0;
                gap = $urandom_range(1, 18);
                repeat (gap) @(posedge clk);
                res_ready <= 1;
            end
            else
                res_ready <= 1;
        end
    end

    // one register write, block idle; the caller drops valid after the last one
    task write_reg(cfg_idx_t idx, logic [2:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WAYS_LOG2)
            tracker.ways_lg = val;
        else
            tracker.cur_mode = mode_t'(val[1:0]);
    endtask

    // send one access transaction, with an optional random gap first;
    // valid stays up after acceptance so back-to-back sends need no gap
    task send(logic [63:0] a, logic op);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            acc_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        acc_valid <= 1;
        acc <= '{address: a, opcode: op};
        do @(posedge clk); while (!acc_ready);
        tracker.note_access('{address: a, opcode: op});
    endtask

    task drain();
        acc_valid <= 0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_geometry(logic [2:0] wl, logic [1:0] md);
        drain();
        write_reg(CFG_WAYS_LOG2, wl);
        write_reg(CFG_MODE, {1'b0, md});
        cfg_valid <= 0;
    endtask

    // a random address: mostly a small working set, sometimes anywhere
    function logic [63:0] pick_addr();
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        return hot_base + ($urandom_range(0, 2047) << 5) + $urandom_range(0, 31);
    endfunction

    initial
    begin
        tracker = new();
        tracker.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, last block wrap, both opcodes, every mode
        set_geometry(3'd0, MODE_LRU);
        send(64'h0, OP_LOAD);
        send(64'h0, OP_STORE);
        send(64'hFFFF_FFFF_FFFF_FFFF, OP_LOAD);
        send(64'hFFFF_FFFF_FFFF_FFFF, OP_STORE);
        set_geometry(3'd4, MODE_PF_ALWAYS);
        send(64'hFFFF_FFFF_FFFF_FFE0, OP_LOAD);
        send(64'h0, OP_LOAD);           // hit on the wrapped prefetch
        send(64'hAAAA_AAAA_AAAA_AAAA, OP_STORE);
        send(64'h5555_5555_5555_5555, OP_LOAD);
        set_geometry(3'd7, MODE_NO_WALLOC);  // oversize ways clamp to 16
        send(64'h1234_0000, OP_STORE);  // store miss, no fill
        send(64'h1234_0000, OP_STORE);
        send(64'h1234_0000, OP_LOAD);
        send(64'h1234_0000, OP_STORE);
        set_geometry(3'd2, MODE_PF_MISS);
        for (int i = 0; i < 6; i++)
            send(64'h4000 * i, OP_LOAD);  // same set, forces eviction
        send(64'h0, OP_LOAD);
        // shrink without flushing: stale ranks above new ways-1
        set_geometry(3'd1, MODE_LRU);
        send(64'h4000, OP_LOAD);
        send(64'h8000, OP_STORE);
        send(64'h0, OP_LOAD);

        // random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            set_geometry(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
            hot_base = {$urandom, $urandom} & ~64'h1F;
            for (int n = 0; n < 140; n++)
                send(pick_addr(), 1'($urandom_range(0, 1)));
            if (ph == 5)
                drain();                // sender holds off until all results are in
        end
        calm = 1;
        for (int n = 0; n < 150; n++)
            send(pick_addr(), 1'($urandom_range(0, 1)));

        drain();
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
